// ===== rtl/fused_axpy_8col_single_assert.svh =====
// Assertion macros shared by the fused axpy RTL.
// No dependencies; included by modules that carry checks.
`ifndef FUSED_AXPY_8COL_SINGLE_ASSERT_SVH
`define FUSED_AXPY_8COL_SINGLE_ASSERT_SVH
`define FAX_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("fax check failed");
`define FAX_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("fax check failed");
`endif

// ===== rtl/fax_pkg.sv =====
// Package for the fused axpy block: widths, constants, float helpers.
// No dependencies.
package fax_pkg;
  localparam int Columns = 8;
  localparam logic [31:0] Qnan = 32'h7FC00000;

  function automatic logic is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction
  function automatic logic is_inf(input logic [31:0] v);
    return v[30:0] == 31'h7F800000;
  endfunction
  function automatic logic is_zero(input logic [31:0] v);
    return v[30:0] == 31'd0;
  endfunction

  // Leading zero count of a 64-bit word.
  function automatic logic [6:0] lzc64(input logic [63:0] x);
    logic [6:0] n;
    logic found;
    n = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && x[i]) begin
        n = 7'(63 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Value = sig * 2^(e-153); sig nonzero. Round to nearest even and pack.
  function automatic logic [31:0] round_pack(input logic sign, input logic signed [11:0] e,
                                             input logic [63:0] sig);
    logic [6:0] lz;
    logic signed [11:0] ex;
    logic [63:0] nm;
    logic [27:0] s28;
    logic [2:0] rb;
    logic [24:0] m;
    logic [11:0] sh;
    logic [63:0] t;
    logic stk;
    lz = lzc64(sig);
    nm = sig << lz;
    // normalized to bit 26 of a 28-bit view, sticky of dropped bits
    s28 = {1'b0, nm[63:37]} | {27'd0, nm[36:0] != 37'd0};
    ex = e + 12'sd37 - $signed({5'd0, lz});
    if (ex >= 12'sd255) return {sign, 31'h7F800000};
    if (ex <= 12'sd0) begin
      sh = 12'(12'sd1 - ex);
      if (sh >= 12'd28) t = {63'd0, s28 != 28'd0};
      else begin
        t = {36'd0, s28} >> sh[4:0];
        stk = (({36'd0, s28} & ((64'd1 << sh[4:0]) - 64'd1)) != 64'd0);
        t[0] = t[0] | stk;
      end
      rb = t[2:0];
      m = {1'b0, t[26:3]};
      if (rb > 3'd4 || (rb == 3'd4 && m[0])) m = m + 25'd1;
      return {sign, 7'd0, m[23:0]};
    end
    rb = s28[2:0];
    m = {1'b0, s28[26:3]};
    if (rb > 3'd4 || (rb == 3'd4 && m[0])) m = m + 25'd1;
    if (m[24]) begin
      m = m >> 1;
      ex = ex + 12'sd1;
    end
    if (ex >= 12'sd255) return {sign, 31'h7F800000};
    return {sign, ex[7:0], m[22:0]};
  endfunction
endpackage

// ===== rtl/fused_axpy_8col_single.sv =====
// Fused axpy over eight columns, one row per word, pipelined multiply-add chain.
// The block streams rows at one word per clock while the output is not held;
// a row's result passes, per column, through one multiply stage pair and
// one add stage pair, all stalling together when the output is held.
// Depends on fax_pkg, fax_mul, fax_add and fused_axpy_8col_single_assert.svh.
`include "fused_axpy_8col_single_assert.svh"
module fused_axpy_8col_single #(
  parameter int COLUMNS = fax_pkg::Columns
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,   // y_in, a_col0 .. a_col7
  input  logic         s_tlast,   // last_in
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // y_out
  output logic         m_tlast,   // last_out
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  localparam int Depth = 4 * COLUMNS;
  logic [31:0] coef [8];
  logic        en;
  logic [Depth:0] vld;
  logic [Depth:0] lst;
  logic [31:0] acc [COLUMNS+1];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 8; j++) coef[j] <= 32'd0;
    end else if (cfg_valid) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  assign en = !vld[Depth] || m_tready;
  assign s_tready = en;
  assign vld[0] = s_tvalid;
  assign lst[0] = s_tlast;
  assign acc[0] = s_tdata[31:0];

  always_ff @(posedge clk) begin
    if (rst) vld[Depth:1] <= '0;
    else if (en) vld[Depth:1] <= vld[Depth-1:0];
  end
  always_ff @(posedge clk) begin
    if (en) lst[Depth:1] <= lst[Depth-1:0];
  end

  // Delay lines carry the a-columns to their stage.
  for (genvar j = 0; j < COLUMNS; j++) begin : g_col
    logic [31:0] prod, prod_q, sum;
    logic [31:0] y_d1, y_d2, y_d3;
    logic [31:0] a_in;
    logic [31:0] adl [4*j+1];
    assign adl[0] = s_tdata[32*(j+1) +: 32];
    for (genvar k = 0; k < 4*j; k++) begin : g_adl
      always_ff @(posedge clk) if (en) adl[k+1] <= adl[k];
    end
    assign a_in = adl[4*j];
    fax_mul u_mul (.clk(clk), .en(en), .a(coef[j]), .b(a_in), .p(prod));
    always_ff @(posedge clk) begin
      if (en) begin
        prod_q <= prod;
        y_d1 <= acc[j];
        y_d2 <= y_d1;
      end
    end
    fax_add u_add (.clk(clk), .en(en), .a(y_d2), .b(prod_q), .s(sum));
    always_ff @(posedge clk) if (en) y_d3 <= sum;
    assign acc[j+1] = y_d3;
  end

  assign m_tvalid = vld[Depth];
  assign m_tlast  = lst[Depth];
  assign m_tdata  = acc[COLUMNS];

  `FAX_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid)
  `FAX_ASSERT(a_ready, s_tready == (!m_tvalid || m_tready))
  `FAX_ASSERT_NEXT(a_flow, en && vld[Depth-1], m_tvalid)
endmodule

// ===== rtl/fax_mul.sv =====
// One registered single-precision multiply stage (product, then round).
// Depends on fax_pkg.
module fax_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);
  logic        spec, spec_q;
  logic [31:0] spec_val, spec_val_q;
  logic [47:0] prod_q;
  logic        sign_q;
  logic signed [11:0] e_q;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;

  always_comb begin
    spec = 1'b1;
    spec_val = fax_pkg::Qnan;
    if (fax_pkg::is_nan(a) || fax_pkg::is_nan(b)) spec_val = fax_pkg::Qnan;
    else if (fax_pkg::is_inf(a) || fax_pkg::is_inf(b)) begin
      if (fax_pkg::is_zero(a) || fax_pkg::is_zero(b)) spec_val = fax_pkg::Qnan;
      else spec_val = {a[31] ^ b[31], 31'h7F800000};
    end else if (fax_pkg::is_zero(a) || fax_pkg::is_zero(b)) spec_val = {a[31] ^ b[31], 31'd0};
    else spec = 1'b0;
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q <= ma * mb;
      spec_q <= spec;
      spec_val_q <= spec_val;
      sign_q <= a[31] ^ b[31];
      e_q <= $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd147;
    end
  end

  assign p = spec_q ? spec_val_q : fax_pkg::round_pack(sign_q, e_q, {16'd0, prod_q});
endmodule

// ===== rtl/fax_add.sv =====
// Single-precision adder stage: align and add, register, then normalize and round.
// Depends on fax_pkg.
module fax_add (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] s
);
  logic        spec, spec_q;
  logic [31:0] spec_val, spec_val_q;
  logic [31:0] big, sml;
  logic [7:0]  eb, es, d;
  logic [63:0] mb, ms, sig, sig_q;
  logic        sign_q;
  logic signed [11:0] e_q;

  always_comb begin
    spec = 1'b1;
    spec_val = 32'd0;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d = eb - es;
    mb = {8'd0, big[30:23] != 8'd0, big[22:0], 32'd0};
    ms = {8'd0, sml[30:23] != 8'd0, sml[22:0], 32'd0};
    if (d >= 8'd64) ms = {63'd0, ms != 64'd0};
    else ms = (ms >> d[5:0]) | {63'd0, (ms & ((64'd1 << d[5:0]) - 64'd1)) != 64'd0};
    sig = (big[31] == sml[31]) ? mb + ms : mb - ms;
    if (fax_pkg::is_nan(a) || fax_pkg::is_nan(b)) spec_val = fax_pkg::Qnan;
    else if (fax_pkg::is_inf(a) && fax_pkg::is_inf(b))
      spec_val = (a[31] ^ b[31]) ? fax_pkg::Qnan : a;
    else if (fax_pkg::is_inf(a)) spec_val = a;
    else if (fax_pkg::is_inf(b)) spec_val = b;
    else if (fax_pkg::is_zero(a) && fax_pkg::is_zero(b)) spec_val = {a[31] & b[31], 31'd0};
    else if (fax_pkg::is_zero(a)) spec_val = b;
    else if (fax_pkg::is_zero(b)) spec_val = a;
    else if (sig == 64'd0) spec_val = 32'd0;
    else spec = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec_q <= spec;
      spec_val_q <= spec_val;
      sig_q <= sig;
      sign_q <= big[31];
      e_q <= $signed({4'd0, eb}) - 12'sd29;
    end
  end

  assign s = spec_q ? spec_val_q : fax_pkg::round_pack(sign_q, e_q, sig_q);
endmodule
